[rtl/wasm_custom_section_scanner_macros.svh]
// assertion macros for the wasm custom section scanner checker
// no dependencies; included by the checker file only
`ifndef WASM_CUSTOM_SECTION_SCANNER_MACROS_SVH
`define WASM_CUSTOM_SECTION_SCANNER_MACROS_SVH

// same-cycle implication
`define WCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wcs check failed");

// next-cycle implication
`define WCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wcs check failed");

`endif

[rtl/wcs_pkg.sv]
// types, codes and constants of the wasm custom section scanner
// no dependencies; imported by every module of the block
package wcs_pkg;

	localparam int WCS_NAME_BYTES = 8;
	localparam int CFG_W = 64;
	localparam int CFG_NAME_BYTES = 8;
	localparam int LEN_W = 32;
	localparam int TLEN_W = 4;
	localparam int LEB_MAX_BYTES = 5;
	localparam int HEADER_BYTES = 8;

	typedef enum logic [1:0] {
		CFG_MODULE_LENGTH = 2'd0,
		CFG_TARGET_NAME   = 2'd1,
		CFG_TARGET_LENGTH = 2'd2,
		CFG_UNUSED        = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_ID      = 3'd1,
		PH_SIZE    = 3'd2,
		PH_SKIP    = 3'd3,
		PH_NAMELEN = 3'd4,
		PH_NAME    = 3'd5,
		PH_PAYLOAD = 3'd6,
		PH_DONE    = 3'd7
	} phase_t;

	typedef enum logic [3:0] {
		ST_BUSY       = 4'd0,
		ST_FOUND      = 4'd1,
		ST_NOT_FOUND  = 4'd2,
		ST_SHORT      = 4'd3,
		ST_MAGIC      = 4'd4,
		ST_VERSION    = 4'd5,
		ST_TRUNC      = 4'd6,
		ST_LONG       = 4'd7,
		ST_SECT_OVER  = 4'd8,
		ST_NAME_OVER  = 4'd9
	} status_t;

	typedef struct packed {
		logic [LEN_W-1:0] acc;
		logic [2:0]       count;
		logic             more;
	} leb_res_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] r;
		unique case (idx)
			2'd0: r = 8'h00;
			2'd1: r = 8'h61;
			2'd2: r = 8'h73;
			default: r = 8'h6d;
		endcase
		return r;
	endfunction

endpackage

[rtl/wcs_leb_step.sv]
// one LEB128 byte folded into the running accumulator
// depends on wcs_pkg
module wcs_leb_step (
	input  logic [wcs_pkg::LEN_W-1:0] acc,
	input  logic [2:0]                count,
	input  logic [7:0]                data,
	output wcs_pkg::leb_res_t         res
);
	import wcs_pkg::*;

	logic [5:0] shift_full;
	logic [4:0] shift;

	assign shift_full = {3'b000, count} * 6'd7;
	assign shift      = shift_full[4:0];

	assign res.acc   = acc | ({{(LEN_W-7){1'b0}}, data[6:0]} << shift);
	assign res.count = count + 3'd1;
	assign res.more  = data[7];

endmodule

[rtl/wasm_custom_section_scanner.sv]
// an accepted byte's result is registered and shows in the cycle after it is accepted
// throughput: one byte per cycle unless stalled; set by the single next-state stage of the parser
// stall on the result side holds the output register and stalls the input
// reset (arst_n low, asynchronous): parser back to the header, parser status busy,
// registers module_length 0, target name 0, target length 7
module wasm_custom_section_scanner #(
	parameter int NAME_BYTES = wcs_pkg::WCS_NAME_BYTES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  wcs_pkg::cfg_index_t       cfg_index,
	input  logic [wcs_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                module_byte,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                payload_byte,
	output logic                      payload_valid,
	output logic                      payload_last,
	output logic                      done_res,
	output logic [3:0]                status
);
	import wcs_pkg::*;

	localparam int IDX_W = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;

	// configuration
	logic [LEN_W-1:0]  mlen_q;
	logic [7:0]        target_q [NAME_BYTES];
	logic [TLEN_W-1:0] tlen_q;

	// parser state
	phase_t           phase_q, phase_d;
	status_t          fstat_q, fstat_d;
	logic [LEN_W-1:0] pos_q, pos_d;
	logic [LEN_W-1:0] acc_q, acc_d;
	logic [2:0]       cnt_q, cnt_d;
	logic [LEN_W-1:0] end_q, end_d;
	logic             custom_q, custom_d;
	logic [LEN_W-1:0] left_q, left_d;
	logic             match_q, match_d;

	// result register
	logic       out_valid_q;
	logic [7:0] pbyte_q;
	logic       pvalid_q, plast_q, done_q;
	status_t    status_q;

	logic       pvalid_d, plast_d;
	logic [7:0] pbyte_d;
	logic       accept;

	leb_res_t leb;

	wcs_leb_step u_leb (
		.acc   (acc_q),
		.count (cnt_q),
		.data  (module_byte),
		.res   (leb)
	);

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mlen_q <= '0;
			tlen_q <= TLEN_W'(7);
			for (int i = 0; i < NAME_BYTES; i++) begin
				target_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODULE_LENGTH: mlen_q <= cfg_data[LEN_W-1:0];
				CFG_TARGET_NAME: begin
					for (int i = 0; i < NAME_BYTES; i++) begin
						if (i < CFG_NAME_BYTES)
							target_q[i] <= cfg_data[8*(i%CFG_NAME_BYTES) +: 8];
						else
							target_q[i] <= '0;
					end
				end
				CFG_TARGET_LENGTH: tlen_q <= cfg_data[TLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [LEN_W-1:0] pos_inc;
		logic [LEN_W:0]   sum;
		logic [LEN_W-1:0] idx;
		logic [IDX_W-1:0] sel;
		logic             tlen_ok;
		logic             an_go;
		logic             an_match;

		phase_d  = phase_q;
		fstat_d  = fstat_q;
		pos_d    = pos_q;
		acc_d    = acc_q;
		cnt_d    = cnt_q;
		end_d    = end_q;
		custom_d = custom_q;
		left_d   = left_q;
		match_d  = match_q;
		pbyte_d  = '0;
		pvalid_d = 1'b0;
		plast_d  = 1'b0;

		pos_inc  = pos_q + LEN_W'(1);
		sum      = {1'b0, pos_inc} + {1'b0, leb.acc};
		idx      = acc_q - left_q;
		sel      = (idx < LEN_W'(NAME_BYTES)) ? idx[IDX_W-1:0] : '0;
		tlen_ok  = 32'(tlen_q) <= NAME_BYTES;
		an_go    = 1'b0;
		an_match = 1'b0;

		if (phase_q != PH_DONE && phase_q != PH_HEADER && pos_q >= mlen_q) begin
			phase_d = PH_DONE;
			priority if (phase_q == PH_ID)
				fstat_d = ST_NOT_FOUND;
			else if (phase_q == PH_SIZE || phase_q == PH_NAMELEN)
				fstat_d = ST_TRUNC;
			else
				fstat_d = ST_SECT_OVER;
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					priority if (mlen_q < LEN_W'(HEADER_BYTES)) begin
						phase_d = PH_DONE;
						fstat_d = ST_SHORT;
					end else if (pos_q < LEN_W'(4)) begin
						if (module_byte != magic_byte(pos_q[1:0])) begin
							phase_d = PH_DONE;
							fstat_d = ST_MAGIC;
						end else begin
							pos_d = pos_inc;
						end
					end else if (module_byte != ((pos_q == LEN_W'(4)) ? 8'd1 : 8'd0)) begin
						phase_d = PH_DONE;
						fstat_d = ST_VERSION;
					end else begin
						pos_d = pos_inc;
						if (pos_inc >= LEN_W'(HEADER_BYTES)) begin
							phase_d = PH_ID;
							if (pos_inc >= mlen_q) begin
								phase_d = PH_DONE;
								fstat_d = ST_NOT_FOUND;
							end
						end
					end
				end
				PH_ID: begin
					custom_d = (module_byte == 8'd0);
					pos_d    = pos_inc;
					acc_d    = '0;
					cnt_d    = '0;
					phase_d  = PH_SIZE;
					if (pos_inc >= mlen_q) begin
						phase_d = PH_DONE;
						fstat_d = ST_TRUNC;
					end
				end
				PH_SIZE, PH_NAMELEN: begin
					acc_d = leb.acc;
					cnt_d = leb.count;
					pos_d = pos_inc;
					if (leb.more) begin
						if (leb.count >= 3'(LEB_MAX_BYTES)) begin
							phase_d = PH_DONE;
							fstat_d = ST_LONG;
						end else if (pos_inc >= mlen_q) begin
							phase_d = PH_DONE;
							fstat_d = ST_TRUNC;
						end
					end else if (phase_q == PH_SIZE) begin
						if (sum > {1'b0, mlen_q}) begin
							phase_d = PH_DONE;
							fstat_d = ST_SECT_OVER;
						end else begin
							end_d = sum[LEN_W-1:0];
							priority if (custom_q) begin
								acc_d   = '0;
								cnt_d   = '0;
								phase_d = PH_NAMELEN;
								if (pos_inc >= mlen_q) begin
									phase_d = PH_DONE;
									fstat_d = ST_TRUNC;
								end
							end else if (leb.acc == '0) begin
								phase_d = PH_ID;
								if (pos_inc >= mlen_q) begin
									phase_d = PH_DONE;
									fstat_d = ST_NOT_FOUND;
								end
							end else begin
								phase_d = PH_SKIP;
							end
						end
					end else begin
						if (sum > {1'b0, end_q}) begin
							phase_d = PH_DONE;
							fstat_d = ST_NAME_OVER;
						end else begin
							left_d   = leb.acc;
							match_d  = (leb.acc == LEN_W'(tlen_q)) && tlen_ok;
							an_match = match_d;
							if (leb.acc == '0)
								an_go = 1'b1;
							else
								phase_d = PH_NAME;
						end
					end
				end
				PH_SKIP: begin
					pos_d = pos_inc;
					if (pos_inc >= end_q) begin
						phase_d = PH_ID;
						if (pos_inc >= mlen_q) begin
							phase_d = PH_DONE;
							fstat_d = ST_NOT_FOUND;
						end
					end
				end
				PH_NAME: begin
					match_d = match_q & ~((idx >= LEN_W'(NAME_BYTES)) ||
						(module_byte != target_q[sel]));
					pos_d    = pos_inc;
					left_d   = left_q - LEN_W'(1);
					an_match = match_d;
					if (left_d == '0)
						an_go = 1'b1;
				end
				PH_PAYLOAD: begin
					pbyte_d  = module_byte;
					pvalid_d = 1'b1;
					pos_d    = pos_inc;
					if (pos_inc >= end_q) begin
						plast_d = 1'b1;
						phase_d = PH_DONE;
						fstat_d = ST_FOUND;
					end
				end
				default: ;
			endcase

			// end of a section name
			if (an_go) begin
				priority if (an_match) begin
					if (pos_inc >= end_q) begin
						phase_d = PH_DONE;
						fstat_d = ST_FOUND;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end else if (pos_inc >= end_q) begin
					phase_d = PH_ID;
					if (pos_inc >= mlen_q) begin
						phase_d = PH_DONE;
						fstat_d = ST_NOT_FOUND;
					end
				end else begin
					phase_d = PH_SKIP;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			fstat_q  <= ST_BUSY;
			pos_q    <= '0;
			acc_q    <= '0;
			cnt_q    <= '0;
			end_q    <= '0;
			custom_q <= 1'b0;
			left_q   <= '0;
			match_q  <= 1'b1;
		end else if (accept) begin
			phase_q  <= phase_d;
			fstat_q  <= fstat_d;
			pos_q    <= pos_d;
			acc_q    <= acc_d;
			cnt_q    <= cnt_d;
			end_q    <= end_d;
			custom_q <= custom_d;
			left_q   <= left_d;
			match_q  <= match_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pbyte_q  <= pbyte_d;
			pvalid_q <= pvalid_d;
			plast_q  <= plast_d;
			done_q   <= (phase_d == PH_DONE);
			status_q <= (phase_d == PH_DONE) ? fstat_d : ST_BUSY;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = pbyte_q;
	assign payload_valid = pvalid_q;
	assign payload_last  = plast_q;
	assign done_res      = done_q;
	assign status        = status_q;

endmodule

[rtl/wcs_checker.sv]
// port-level checks of the wasm custom section scanner, bound to the top level
// depends on wcs_pkg and wasm_custom_section_scanner_macros.svh
`include "wasm_custom_section_scanner_macros.svh"

module wcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] payload_byte,
	input logic       payload_valid,
	input logic       payload_last,
	input logic       done_res,
	input logic [3:0] status
);
	import wcs_pkg::*;

	// done and a final status always go together
	`WCS_ASSERT_SAME(a_done_status, clk, arst_n, out_valid, done_res == (status != ST_BUSY))

	// the last payload byte closes the scan as found
	`WCS_ASSERT_SAME(a_last_found, clk, arst_n, out_valid && payload_last,
		payload_valid && done_res && status == ST_FOUND)

	// a payload byte before the last leaves the scan running
	`WCS_ASSERT_SAME(a_mid_payload, clk, arst_n, out_valid && payload_valid && !payload_last,
		!done_res)

	// a stalled transaction holds
	`WCS_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(payload_byte) && $stable(status))

endmodule

bind wasm_custom_section_scanner wcs_checker u_wcs_checker (.*);

[verif/wasm_custom_section_scanner_tb.sv]
// self-checking testbench for wasm_custom_section_scanner: feeds a wasm byte stream,
// predicts every per-byte result and compares the transactions in order
// depends on wcs_pkg and the scanner rtl
`timescale 1ns / 100ps

module wasm_custom_section_scanner_tb;
	import wcs_pkg::*;

	localparam int NAME_BYTES = WCS_NAME_BYTES;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [31:0] WASM_MAGIC = 32'h6d73_6100;

	typedef struct packed {
		logic [7:0] pbyte;
		logic       pvalid;
		logic       plast;
		logic       done;
		logic [3:0] st;
	} scan_result_t;

	typedef enum int {
		END_FOUND, END_EMPTY, END_NOT_FOUND, END_TRUNC, END_LONG, END_SECT_OVER,
		END_LOWERED, END_NAME_OVER, END_MAGIC, END_VERSION, END_SHORT
	} ending_t;

	typedef enum int {NAME_RANDOM, NAME_COPY, NAME_NEAR} name_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_index_t cfg_index = CFG_MODULE_LENGTH;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] module_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] payload_byte;
	logic payload_valid;
	logic payload_last;
	logic done_res;
	logic [3:0] status;

	// scanner state as predicted
	logic [31:0] scan_pos = '0;
	phase_t scan_phase = PH_HEADER;
	logic [31:0] leb_acc = '0;
	logic [2:0] leb_cnt = '0;
	logic [32:0] sect_end = '0;
	logic sect_custom = 1'b0;
	logic [31:0] name_left = '0;
	logic name_ok = 1'b1;
	status_t scan_status = ST_BUSY;
	logic [31:0] mod_len = '0;
	logic [63:0] tgt_name = '0;
	logic [3:0] tgt_len = 4'd7;

	logic [7:0] byte_q[$];
	scan_result_t result_q[$];
	int sent = 0;
	int mismatches = 0;
	int cycle_count = 0;
	logic calm = 1'b0;
	logic next_valid;
	logic [7:0] next_byte;
	int send_gap = 0;
	int stall_left = 0;
	scan_result_t exp_res;
	ending_t ending;

	wasm_custom_section_scanner u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.module_byte(module_byte), .out_valid(out_valid), .out_stall(out_stall),
		.payload_byte(payload_byte), .payload_valid(payload_valid),
		.payload_last(payload_last), .done_res(done_res), .status(status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void end_scan(input status_t code);
		scan_status = code;
		scan_phase = PH_DONE;
	endfunction

	function automatic void begin_leb(input phase_t p);
		leb_acc = '0;
		leb_cnt = '0;
		scan_phase = p;
		if (scan_pos >= mod_len) end_scan(ST_TRUNC);
	endfunction

	function automatic void next_section();
		scan_phase = PH_ID;
		if (scan_pos >= mod_len) end_scan(ST_NOT_FOUND);
	endfunction

	function automatic void name_done();
		if (name_ok) begin
			if ({1'b0, scan_pos} >= sect_end) end_scan(ST_FOUND);
			else scan_phase = PH_PAYLOAD;
		end else if ({1'b0, scan_pos} >= sect_end) begin
			next_section();
		end else begin
			scan_phase = PH_SKIP;
		end
	endfunction

	function automatic bit leb_take(input logic [7:0] b);
		logic [31:0] part;
		part = {25'd0, b[6:0]} << (7 * leb_cnt);
		leb_acc = leb_acc | part;
		leb_cnt = leb_cnt + 3'd1;
		scan_pos = scan_pos + 32'd1;
		if (!b[7]) return 1'b1;
		if (leb_cnt >= 3'd5) end_scan(ST_LONG);
		else if (scan_pos >= mod_len) end_scan(ST_TRUNC);
		return 1'b0;
	endfunction

	function automatic scan_result_t predict_scan(input logic [7:0] b);
		scan_result_t r;
		logic [31:0] idx;
		r = '0;
		if (scan_phase != PH_DONE && scan_phase != PH_HEADER && scan_pos >= mod_len) begin
			if (scan_phase == PH_ID) end_scan(ST_NOT_FOUND);
			else if (scan_phase == PH_SIZE || scan_phase == PH_NAMELEN) end_scan(ST_TRUNC);
			else end_scan(ST_SECT_OVER);
		end else begin
			case (scan_phase)
				PH_HEADER: begin
					if (mod_len < 32'd8) begin
						end_scan(ST_SHORT);
					end else if (scan_pos < 32'd4) begin
						if (b != WASM_MAGIC[8*scan_pos[1:0] +: 8]) end_scan(ST_MAGIC);
						else scan_pos = scan_pos + 32'd1;
					end else if (b != ((scan_pos == 32'd4) ? 8'd1 : 8'd0)) begin
						end_scan(ST_VERSION);
					end else begin
						scan_pos = scan_pos + 32'd1;
						if (scan_pos >= 32'd8) next_section();
					end
				end
				PH_ID: begin
					sect_custom = (b == 8'd0);
					scan_pos = scan_pos + 32'd1;
					begin_leb(PH_SIZE);
				end
				PH_SIZE: begin
					if (leb_take(b)) begin
						if ({1'b0, scan_pos} + leb_acc > {1'b0, mod_len}) begin
							end_scan(ST_SECT_OVER);
						end else begin
							sect_end = {1'b0, scan_pos} + leb_acc;
							if (sect_custom) begin_leb(PH_NAMELEN);
							else if (sect_end == {1'b0, scan_pos}) next_section();
							else scan_phase = PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					scan_pos = scan_pos + 32'd1;
					if ({1'b0, scan_pos} >= sect_end) next_section();
				end
				PH_NAMELEN: begin
					if (leb_take(b)) begin
						if ({1'b0, scan_pos} + leb_acc > sect_end) begin
							end_scan(ST_NAME_OVER);
						end else begin
							name_left = leb_acc;
							name_ok = (leb_acc == {28'd0, tgt_len}) && (tgt_len <= NAME_BYTES);
							if (name_left == 32'd0) name_done();
							else scan_phase = PH_NAME;
						end
					end
				end
				PH_NAME: begin
					idx = leb_acc - name_left;
					if (idx >= NAME_BYTES || b != tgt_name[8*idx[2:0] +: 8]) name_ok = 1'b0;
					scan_pos = scan_pos + 32'd1;
					name_left = name_left - 32'd1;
					if (name_left == 32'd0) name_done();
				end
				PH_PAYLOAD: begin
					r.pbyte = b;
					r.pvalid = 1'b1;
					scan_pos = scan_pos + 32'd1;
					if ({1'b0, scan_pos} >= sect_end) begin
						r.plast = 1'b1;
						end_scan(ST_FOUND);
					end
				end
				default: scan_phase = PH_DONE;
			endcase
		end
		r.done = (scan_phase == PH_DONE);
		r.st = r.done ? scan_status : ST_BUSY;
		return r;
	endfunction

	function automatic int gap_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int pick_leb_n(input logic [31:0] v);
		int m;
		m = 1;
		while (m < 5 && (v >> (7 * m)) != 0) m++;
		return ($urandom_range(0, 3) == 0) ? $urandom_range(m, 5) : m;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		byte_q = {byte_q, b};
		sent++;
	endtask

	// padded encodings allowed; a fifth byte carries junk above bit 31
	task automatic push_leb(input logic [31:0] v, input int n);
		logic [7:0] x;
		for (int i = 0; i < n; i++) begin
			x = 8'((v >> (7 * i)) & 32'h7f);
			if (i < n - 1) x[7] = 1'b1;
			else if (i == 4) x[6:4] = 3'($urandom_range(0, 7));
			push_byte(x);
		end
	endtask

	task automatic push_custom(input int nl, input int clen, input name_mode_t mode,
			input int size_n);
		int nn;
		int sz;
		int flip;
		logic [7:0] x;
		nn = pick_leb_n(nl);
		sz = nn + nl + clen;
		flip = -1;
		if (mode == NAME_NEAR && nl > 0) flip = $urandom_range(0, (nl < 8) ? nl - 1 : 7);
		push_byte(8'h00);
		push_leb(sz, (size_n > 0) ? size_n : pick_leb_n(sz));
		push_leb(nl, nn);
		for (int i = 0; i < nl; i++) begin
			x = (mode != NAME_RANDOM && i < 8) ? tgt_name[8*i +: 8] : 8'($urandom_range(0, 255));
			if (i == flip) x = x ^ 8'($urandom_range(1, 255));
			push_byte(x);
		end
		repeat (clen) push_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
		logic [63:0] d;
		d = {$urandom, $urandom};
		case (idx)
			CFG_MODULE_LENGTH: begin
				d[31:0] = value[31:0];
				mod_len = value[31:0];
			end
			CFG_TARGET_NAME: begin
				d = value;
				tgt_name = value;
			end
			CFG_TARGET_LENGTH: begin
				d[3:0] = value[3:0];
				tgt_len = value[3:0];
			end
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		while (byte_q.size() != 0 || in_valid || result_q.size() != 0) @(negedge clk);
	endtask

	task automatic check_field(input string fname, input logic [7:0] e, input logic [7:0] a);
		if (e !== a) begin
			$display("%0t: %s expected %0h actual %0h", $time, fname, e, a);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			next_valid = in_valid;
			next_byte = module_byte;
			if (in_valid && !in_stall) begin
				result_q = {result_q, predict_scan(module_byte)};
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (byte_q.size() > 0) begin
					next_byte = byte_q.pop_front();
					next_valid = 1'b1;
					send_gap = gap_len();
				end
			end
			in_valid <= next_valid;
			module_byte <= next_byte;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected transaction byte %0h status %0d", $time,
						payload_byte, status);
					mismatches++;
				end else begin
					exp_res = result_q.pop_front();
					check_field("payload_byte", exp_res.pbyte, payload_byte);
					check_field("payload_valid", 8'(exp_res.pvalid), 8'(payload_valid));
					check_field("payload_last", 8'(exp_res.plast), 8'(payload_last));
					check_field("done_res", 8'(exp_res.done), 8'(done_res));
					check_field("status", 8'(exp_res.st), 8'(status));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				stall_left = gap_len();
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count % 128 == 0) calm <= ($urandom_range(0, 3) == 0);
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int r;
		int phase;
		int phase_start;
		int nl;
		int sz;
		int tl;
		int bad;
		name_mode_t mode;
		logic [7:0] hdr[8];

		r = $urandom_range(0, 23);
		if (r < 6) ending = END_FOUND;
		else if (r < 8) ending = END_EMPTY;
		else if (r < 11) ending = END_NOT_FOUND;
		else if (r < 13) ending = END_TRUNC;
		else if (r < 15) ending = END_LONG;
		else if (r < 17) ending = END_SECT_OVER;
		else if (r < 19) ending = END_LOWERED;
		else if (r < 21) ending = END_NAME_OVER;
		else if (r == 21) ending = END_MAGIC;
		else if (r == 22) ending = END_VERSION;
		else ending = END_SHORT;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_reg(CFG_MODULE_LENGTH,
			(ending == END_SHORT) ? 64'($urandom_range(0, 7)) : 64'hFFFF_FFFF);
		write_reg(CFG_TARGET_NAME, {$urandom, $urandom});
		write_reg(CFG_TARGET_LENGTH, 64'd8);
		write_reg(CFG_UNUSED, '0);

		hdr = '{8'h00, 8'h61, 8'h73, 8'h6d, 8'h01, 8'h00, 8'h00, 8'h00};
		if (ending == END_MAGIC) begin
			bad = $urandom_range(0, 3);
			hdr[bad] = hdr[bad] ^ 8'($urandom_range(1, 255));
		end else if (ending == END_VERSION) begin
			bad = $urandom_range(4, 7);
			hdr[bad] = hdr[bad] ^ 8'($urandom_range(1, 255));
		end
		for (int i = 0; i < 8; i++) push_byte(hdr[i]);
		// empty plain section, then a custom section with a 9-byte name
		push_byte(8'h01);
		push_byte(8'h00);
		push_custom(9, 0, NAME_COPY, 5);

		if (ending == END_MAGIC || ending == END_VERSION || ending == END_SHORT) begin
			repeat (690) push_byte(8'($urandom_range(0, 255)));
		end else begin
			phase = 0;
			while (sent < 650) begin
				drain();
				phase++;
				if (phase == 1) tl = 0;
				else if (phase == 2) tl = 15;
				else if ($urandom_range(0, 3) == 0) tl = $urandom_range(9, 15);
				else tl = $urandom_range(0, 8);
				write_reg(CFG_TARGET_NAME, {$urandom, $urandom});
				write_reg(CFG_TARGET_LENGTH, 64'(tl));
				if (phase % 3 == 0)
					write_reg(CFG_MODULE_LENGTH, (phase % 2) ?
						64'(scan_pos + 32'd5000 + 32'($urandom_range(0, 1000))) : 64'hFFFF_FFFF);
				if (phase % 4 == 0) write_reg(CFG_UNUSED, '0);
				phase_start = sent;
				while (sent - phase_start < 60) begin
					if ($urandom_range(0, 1)) begin
						sz = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
						push_byte(8'($urandom_range(1, 255)));
						push_leb(sz, pick_leb_n(sz));
						repeat (sz) push_byte(8'($urandom_range(0, 255)));
					end else begin
						nl = $urandom_range(0, 1) ? int'(tgt_len) : $urandom_range(0, 10);
						if (nl == tgt_len && tgt_len <= NAME_BYTES) begin
							if (nl == 0) begin
								nl = $urandom_range(1, 10);
								mode = $urandom_range(0, 1) ? NAME_COPY : NAME_RANDOM;
							end else begin
								mode = NAME_NEAR;
							end
						end else begin
							mode = $urandom_range(0, 1) ? NAME_COPY : NAME_RANDOM;
						end
						push_custom(nl, $urandom_range(0, 8), mode, 0);
					end
				end
			end
			drain();

			case (ending)
				END_FOUND, END_EMPTY: begin
					tl = $urandom_range(0, 8);
					write_reg(CFG_TARGET_NAME, {$urandom, $urandom});
					write_reg(CFG_TARGET_LENGTH, 64'(tl));
					push_custom(tl, (ending == END_FOUND) ? $urandom_range(1, 16) : 0,
						NAME_COPY, 0);
				end
				END_NOT_FOUND: write_reg(CFG_MODULE_LENGTH, 64'(scan_pos));
				END_TRUNC: begin
					write_reg(CFG_MODULE_LENGTH, 64'(scan_pos + 32'($urandom_range(1, 3))));
					push_byte(8'($urandom_range(0, 255)));
					repeat (4) push_byte(8'h80 | 8'($urandom_range(0, 127)));
				end
				END_LONG: begin
					if ($urandom_range(0, 1)) begin
						push_byte(8'($urandom_range(0, 255)));
					end else begin
						push_byte(8'h00);
						push_byte(8'd20);
					end
					repeat (5) push_byte(8'h80 | 8'($urandom_range(0, 127)));
				end
				END_SECT_OVER: begin
					push_byte(8'($urandom_range(0, 255)));
					push_leb(32'hFFFF_FFFF - 32'($urandom_range(0, 15)), 5);
				end
				END_LOWERED: begin
					push_byte(8'($urandom_range(1, 255)));
					push_leb(32'd10, pick_leb_n(32'd10));
					repeat (3) push_byte(8'($urandom_range(0, 255)));
					drain();
					write_reg(CFG_MODULE_LENGTH, 64'(scan_pos - 32'($urandom_range(0, 2))));
				end
				default: begin
					push_byte(8'h00);
					if ($urandom_range(0, 1)) begin
						push_byte(8'h00);
						push_byte(8'($urandom_range(1, 127)));
					end else begin
						push_byte(8'd3);
						push_byte(8'd5);
					end
				end
			endcase
			repeat (10) push_byte(8'($urandom_range(0, 255)));
		end

		drain();
		repeat (5) @(posedge clk);
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule
